>>> src/ctpc_pkg.sv
package ctpc_pkg;

    localparam int PAK_BYTES = 32;
    localparam int CNT_W     = (PAK_BYTES > 1) ? $clog2(PAK_BYTES) : 1;
    localparam int REMAIN_W  = $clog2(PAK_BYTES + 1);

    localparam logic [1:0]  CMD_READ  = 2'd0;
    localparam logic [1:0]  CMD_WRITE = 2'd1;

    localparam logic [7:0]  CRC_POLY    = 8'h85;
    localparam logic [15:0] ADDR_MASK   = 16'hFFE0;
    localparam logic [15:0] MEM_LO      = 16'h8000;
    localparam logic [15:0] MEM_HI      = 16'h9000;
    localparam logic [15:0] RUMBLE_ADDR = 16'hC000;
    localparam logic [7:0]  FILL_BYTE   = 8'h80;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic logic [7:0] read_burst_crc(input logic [7:0] fill);
        logic [7:0] c;
        c = 8'h00;
        for (int k = 0; k < PAK_BYTES; k++)
        begin
            c = crc8_update(c, fill);
        end
        return c;
    endfunction

    localparam logic [7:0] READ_CRC_FILL = read_burst_crc(FILL_BYTE);
    localparam logic [7:0] READ_CRC_ZERO = read_burst_crc(8'h00);

    typedef struct packed {
        logic        valid;
        logic [1:0]  cmd;
        logic [1:0]  port;
        logic [15:0] address;
        logic [7:0]  data_byte;
    } stage_t;

    typedef struct packed {
        logic       final_byte;
        logic [7:0] crc;
        logic       rumble_valid;
        logic       rumble_on;
    } wr_result_t;

endpackage

>>> src/ctpc_if.sv
interface ctpc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [1:0]  port;
    logic [15:0] address;
    logic [7:0]  data_byte;

    modport source (output valid, cmd, port, address, data_byte, input ready);
    modport sink   (input valid, cmd, port, address, data_byte, output ready);
endinterface

interface ctpc_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_port;
    logic [7:0] out_byte;
    logic       is_crc;
    logic       last;
    logic       rumble_valid;
    logic       rumble_on;

    modport source (output valid, out_port, out_byte, is_crc, last, rumble_valid, rumble_on,
                    input ready);
    modport sink   (input valid, out_port, out_byte, is_crc, last, rumble_valid, rumble_on,
                    output ready);
endinterface

>>> src/controller_pak_transfer_crc_core.sv
// Channel | Direction | Payload
// req     | in        | cmd, port, address, data_byte
// rsp     | out       | out_port, out_byte, is_crc, last, rumble_valid, rumble_on
//
// Write bytes and ignored commands are taken one per cycle; the CRC step is
// eight XOR stages between the input register and the write state.
// A read item holds the output register for PAK_BYTES fill bytes and its CRC
// byte; input stalls only while a read burst or a write CRC waits for it.
// rst_n clears all control and CRC state asynchronously.
module controller_pak_transfer_crc_core (
    input  logic       clk,
    input  logic       rst_n,
    ctpc_req_if.sink   req,
    ctpc_rsp_if.source rsp
);
    import ctpc_pkg::*;

    stage_t     stage;
    wr_result_t wr;
    logic       take;

    ctpc_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .take  (take),
        .stage (stage)
    );

    ctpc_wr_crc u_wr_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .take  (take),
        .wr    (wr)
    );

    ctpc_out_ctrl u_out_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .wr    (wr),
        .take  (take),
        .rsp   (rsp)
    );
endmodule

>>> src/ctpc_in_stage.sv
module ctpc_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    ctpc_req_if.sink        req,
    input  logic            take,
    output ctpc_pkg::stage_t stage
);
    import ctpc_pkg::*;

    logic        valid_reg;
    logic [1:0]  cmd_reg;
    logic [1:0]  port_reg;
    logic [15:0] address_reg;
    logic [7:0]  data_reg;
    logic        load;

    assign req.ready = !valid_reg || take;
    assign load      = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg     <= req.cmd;
            port_reg    <= req.port;
            address_reg <= req.address;
            data_reg    <= req.data_byte;
        end
    end

    assign stage.valid     = valid_reg;
    assign stage.cmd       = cmd_reg;
    assign stage.port      = port_reg;
    assign stage.address   = address_reg;
    assign stage.data_byte = data_reg;
endmodule

>>> src/ctpc_wr_crc.sv
module ctpc_wr_crc (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctpc_pkg::stage_t     stage,
    input  logic                 take,
    output ctpc_pkg::wr_result_t wr
);
    import ctpc_pkg::*;

    logic [7:0]       crc_reg, crc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             hit_reg, hit_next;
    logic             nonzero_reg, nonzero_next;
    logic             first;
    logic             final_byte;
    logic             update;

    assign first      = (count_reg == '0);
    assign final_byte = (count_reg == CNT_W'(PAK_BYTES - 1));
    assign update     = take && stage.valid && (stage.cmd == CMD_WRITE);

    always_comb
    begin
        crc_next     = crc8_update(first ? 8'h00 : crc_reg, stage.data_byte);
        hit_next     = first ? ((stage.address & ADDR_MASK) == RUMBLE_ADDR) : hit_reg;
        nonzero_next = first ? (stage.data_byte != 8'h00) : nonzero_reg;
        count_next   = final_byte ? '0 : count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= 8'h00;
            count_reg   <= '0;
            hit_reg     <= 1'b0;
            nonzero_reg <= 1'b0;
        end
        else if (update)
        begin
            crc_reg     <= crc_next;
            count_reg   <= count_next;
            hit_reg     <= hit_next;
            nonzero_reg <= nonzero_next;
        end
    end

    assign wr.final_byte   = final_byte;
    assign wr.crc          = crc_next;
    assign wr.rumble_valid = hit_next;
    assign wr.rumble_on    = hit_next && nonzero_next;
endmodule

>>> src/ctpc_out_ctrl.sv
module ctpc_out_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctpc_pkg::stage_t     stage,
    input  ctpc_pkg::wr_result_t wr,
    output logic                 take,
    ctpc_rsp_if.source           rsp
);
    import ctpc_pkg::*;

    logic                valid_reg, valid_next;
    logic [REMAIN_W-1:0] remain_reg, remain_next;
    logic                fill_reg, fill_next;
    logic [1:0]          port_reg, port_next;
    logic [7:0]          byte_reg, byte_next;
    logic                is_crc_reg, is_crc_next;
    logic                last_reg, last_next;
    logic                rv_reg, rv_next;
    logic                ro_reg, ro_next;

    logic        is_read;
    logic        needs_slot;
    logic        slot_free;
    logic        advance;
    logic [15:0] masked;
    logic        in_mem;

    assign masked     = stage.address & ADDR_MASK;
    assign in_mem     = (masked >= MEM_LO) && (masked < MEM_HI);
    assign is_read    = (stage.cmd == CMD_READ);
    assign needs_slot = is_read || ((stage.cmd == CMD_WRITE) && wr.final_byte);
    assign advance    = valid_reg && rsp.ready;
    assign slot_free  = !valid_reg || (rsp.ready && (remain_reg == '0));
    assign take       = stage.valid && (!needs_slot || slot_free);

    always_comb
    begin
        valid_next  = valid_reg;
        remain_next = remain_reg;
        fill_next   = fill_reg;
        port_next   = port_reg;
        byte_next   = byte_reg;
        is_crc_next = is_crc_reg;
        last_next   = last_reg;
        rv_next     = rv_reg;
        ro_next     = ro_reg;
        if (take && needs_slot)
        begin
            valid_next = 1'b1;
            port_next  = stage.port;
            if (is_read)
            begin
                remain_next = REMAIN_W'(PAK_BYTES);
                fill_next   = in_mem;
                byte_next   = in_mem ? FILL_BYTE : 8'h00;
                is_crc_next = 1'b0;
                last_next   = 1'b0;
                rv_next     = 1'b0;
                ro_next     = 1'b0;
            end
            else
            begin
                remain_next = '0;
                byte_next   = wr.crc;
                is_crc_next = 1'b1;
                last_next   = 1'b1;
                rv_next     = wr.rumble_valid;
                ro_next     = wr.rumble_on;
            end
        end
        else if (advance)
        begin
            if (remain_reg == '0)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                remain_next = remain_reg - REMAIN_W'(1);
                if (remain_reg == REMAIN_W'(1))
                begin
                    byte_next   = fill_reg ? READ_CRC_FILL : READ_CRC_ZERO;
                    is_crc_next = 1'b1;
                    last_next   = 1'b1;
                end
                else
                begin
                    byte_next = fill_reg ? FILL_BYTE : 8'h00;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg   <= fill_next;
        port_reg   <= port_next;
        byte_reg   <= byte_next;
        is_crc_reg <= is_crc_next;
        last_reg   <= last_next;
        rv_reg     <= rv_next;
        ro_reg     <= ro_next;
    end

    assign rsp.valid        = valid_reg;
    assign rsp.out_port     = port_reg;
    assign rsp.out_byte     = byte_reg;
    assign rsp.is_crc       = is_crc_reg;
    assign rsp.last         = last_reg;
    assign rsp.rumble_valid = rv_reg;
    assign rsp.rumble_on    = ro_reg;
endmodule

>>> sim/controller_pak_transfer_crc_core_tb.sv
module controller_pak_transfer_crc_core_tb;

    import ctpc_pkg::*;

    localparam logic [1:0] CMD_IGNORE  = 2'd2;
    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         N_DIRECTED  = 17;
    localparam int         TOTAL_ITEMS = 270;
    localparam int         HOLD_CYCLES = 300;
    localparam int         STALL_LIMIT = 2000;
    localparam int         DRAIN_CYCLES = 40;

    typedef enum {PACE_OPEN, PACE_COIN, PACE_SPARSE, PACE_BEAT} pace_t;

    typedef struct packed {
        logic [1:0] port;
        logic [7:0] value;
        logic       is_crc;
        logic       last;
        logic       rumble_valid;
        logic       rumble_on;
    } pak_result_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  port;
        logic [15:0] address;
        logic [7:0]  data;
        logic        typed;
        logic [7:0]  fill;
    } pak_stim_t;

    logic clk = 1'b0;
    logic rst_n;

    ctpc_req_if req();
    ctpc_rsp_if rsp();

    controller_pak_transfer_crc_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // typed fill for directed reads travels beside the item
    logic       dir_typed;
    logic [7:0] dir_fill;

    pak_result_t expected_results[$];
    pak_stim_t   directed_items [0:N_DIRECTED-1];

    logic [7:0] wr_crc;
    int         wr_count;
    logic       wr_rumble_hit;
    logic       wr_first_nz;

    int wr_sent      = 0;
    int stim_items   = 0;
    int burst_left   = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;
    int results_seen = 0;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] pak_crc_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8)
        begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    task automatic report_error(input string msg);
        if (mismatches < 50)
        begin
            $display("ERROR: %s", msg);
        end
        mismatches++;
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [1:0] port,
                             input logic [15:0] address, input logic [7:0] data,
                             input logic typed = 1'b0, input logic [7:0] fill = 8'h00);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(1, 10);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        req.valid     <= 1'b1;
        req.cmd       <= cmd;
        req.port      <= port;
        req.address   <= address;
        req.data_byte <= data;
        dir_typed     <= typed;
        dir_fill      <= fill;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        if (cmd == CMD_WRITE)
        begin
            wr_sent = (wr_sent + 1) % PAK_BYTES;
        end
        if (cmd == CMD_READ || cmd == CMD_WRITE)
        begin
            stim_items++;
        end
    endtask

    task automatic send_random_read();
        logic [15:0] a;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            a = MEM_LO + 16'($urandom_range(0, 16'h0FFF));
        end
        else if (r < 60)
        begin
            case ($urandom_range(0, 3))
                0:       a = MEM_LO - 16'd1;
                1:       a = MEM_HI;
                2:       a = MEM_HI - 16'd1;
                default: a = 16'hFFFF;
            endcase
        end
        else
        begin
            a = 16'($urandom);
        end
        send_item(CMD_READ, 2'($urandom), a, 8'($urandom));
    endtask

    task automatic send_random_other();
        send_item($urandom_range(0, 1) ? CMD_IGNORE : CMD_SPARE, 2'($urandom),
                  16'($urandom), 8'($urandom));
    endtask

    // write bytes, now and then broken up by a read or an ignored command
    task automatic send_write_bytes(input int n);
        logic [15:0] a;
        logic [7:0]  d;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 6)
            begin
                if ($urandom_range(0, 1))
                begin
                    send_random_read();
                end
                else
                begin
                    send_random_other();
                end
            end
            a = 16'($urandom);
            if (wr_sent == 0)
            begin
                if ($urandom_range(0, 99) < 50)
                begin
                    a = RUMBLE_ADDR | 16'($urandom_range(0, 31));
                end
                d = ($urandom_range(0, 99) < 40) ? 8'h00 : 8'($urandom);
            end
            else
            begin
                d = ($urandom_range(0, 99) < 10) ? 8'h00 : 8'($urandom);
            end
            send_item(CMD_WRITE, 2'($urandom), a, d);
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        pak_result_t got;
        pak_result_t want;
        logic [15:0] masked;
        logic [7:0]  fill;
        logic [7:0]  crc;
        bit          moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                moved = 1'b1;
                got = '{rsp.out_port, rsp.out_byte, rsp.is_crc, rsp.last,
                        rsp.rumble_valid, rsp.rumble_on};
                if (expected_results.size() == 0)
                begin
                    report_error($sformatf("result %0d unexpected: byte %0h",
                                           results_seen, got.value));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.port != want.port)
                        report_error($sformatf("result %0d out_port %0h expected %0h",
                                               results_seen, got.port, want.port));
                    if (got.value != want.value)
                        report_error($sformatf("result %0d out_byte %0h expected %0h",
                                               results_seen, got.value, want.value));
                    if (got.is_crc != want.is_crc)
                        report_error($sformatf("result %0d is_crc %0b expected %0b",
                                               results_seen, got.is_crc, want.is_crc));
                    if (got.last != want.last)
                        report_error($sformatf("result %0d last %0b expected %0b",
                                               results_seen, got.last, want.last));
                    if (got.rumble_valid != want.rumble_valid)
                        report_error($sformatf("result %0d rumble_valid %0b expected %0b",
                                               results_seen, got.rumble_valid,
                                               want.rumble_valid));
                    if (got.rumble_on != want.rumble_on)
                        report_error($sformatf("result %0d rumble_on %0b expected %0b",
                                               results_seen, got.rumble_on, want.rumble_on));
                end
                results_seen++;
            end
            if (req.valid && req.ready)
            begin
                moved = 1'b1;
                if (req.cmd == CMD_READ)
                begin
                    masked = req.address & ADDR_MASK;
                    if (dir_typed)
                        fill = dir_fill;
                    else
                        fill = (masked >= MEM_LO && masked < MEM_HI) ? FILL_BYTE : 8'h00;
                    crc = 8'h00;
                    for (int k = 0; k < PAK_BYTES; k++)
                    begin
                        expected_results.push_back('{req.port, fill, 1'b0, 1'b0, 1'b0, 1'b0});
                        crc = pak_crc_next(crc, fill);
                    end
                    expected_results.push_back('{req.port, crc, 1'b1, 1'b1, 1'b0, 1'b0});
                end
                else if (req.cmd == CMD_WRITE)
                begin
                    if (wr_count == 0)
                    begin
                        wr_rumble_hit = ((req.address & ADDR_MASK) == RUMBLE_ADDR);
                        wr_first_nz   = (req.data_byte != 8'h00);
                        wr_crc        = 8'h00;
                    end
                    wr_crc = pak_crc_next(wr_crc, req.data_byte);
                    wr_count++;
                    if (wr_count >= PAK_BYTES)
                    begin
                        expected_results.push_back('{req.port, wr_crc, 1'b1, 1'b1,
                                                     wr_rumble_hit,
                                                     wr_rumble_hit & wr_first_nz});
                        wr_count = 0;
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin : rsp_pacing
        pace_t mode;
        int    span;
        int    tick;
        tick = 0;
        rsp.ready = 1'b0;
        forever
        begin
            if (hold_req && !hold_done)
            begin
                // long back-pressure so the block fills and stalls its input
                hold_done = 1'b1;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = pace_t'($urandom_range(0, 3));
                span = $urandom_range(10, 60);
                repeat (span)
                begin
                    case (mode)
                        PACE_OPEN:   rsp.ready <= 1'b1;
                        PACE_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
                        PACE_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
                        default:     rsp.ready <= (tick % 3 != 0);
                    endcase
                    tick++;
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int pick;
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.cmd       = CMD_IGNORE;
        req.port      = 2'd0;
        req.address   = 16'h0000;
        req.data_byte = 8'h00;
        dir_typed     = 1'b0;
        dir_fill      = 8'h00;
        wr_crc        = 8'h00;
        wr_count      = 0;
        wr_rumble_hit = 1'b0;
        wr_first_nz   = 1'b0;

        directed_items = '{
            '{CMD_READ,   2'd0, 16'h0000, 8'h00, 1'b1, 8'h00},
            '{CMD_READ,   2'd1, 16'h8000, 8'h00, 1'b1, FILL_BYTE},
            '{CMD_READ,   2'd2, 16'h8FFF, 8'hFF, 1'b1, FILL_BYTE},
            '{CMD_READ,   2'd3, 16'h9000, 8'hA5, 1'b1, 8'h00},
            '{CMD_READ,   2'd0, 16'h7FFF, 8'h00, 1'b1, 8'h00},
            '{CMD_READ,   2'd1, 16'hFFFF, 8'hFF, 1'b1, 8'h00},
            '{CMD_READ,   2'd2, 16'h801F, 8'h00, 1'b1, FILL_BYTE},
            '{CMD_IGNORE, 2'd3, 16'h8000, 8'hFF, 1'b0, 8'h00},
            '{CMD_SPARE,  2'd0, 16'hFFFF, 8'hFF, 1'b0, 8'h00},
            '{CMD_WRITE,  2'd1, 16'hC01F, 8'hFF, 1'b0, 8'h00},
            '{CMD_WRITE,  2'd2, 16'h0000, 8'h00, 1'b0, 8'h00},
            '{CMD_WRITE,  2'd3, 16'hFFFF, 8'h80, 1'b0, 8'h00},
            '{CMD_READ,   2'd0, 16'h8000, 8'h00, 1'b1, FILL_BYTE},
            '{CMD_IGNORE, 2'd1, 16'hC000, 8'h55, 1'b0, 8'h00},
            '{CMD_WRITE,  2'd0, 16'h1234, 8'h01, 1'b0, 8'h00},
            '{CMD_READ,   2'd3, 16'h0000, 8'h00, 1'b1, 8'h00},
            '{CMD_SPARE,  2'd2, 16'h0000, 8'h00, 1'b0, 8'h00}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_item(directed_items[i].cmd, directed_items[i].port,
                      directed_items[i].address, directed_items[i].data,
                      directed_items[i].typed, directed_items[i].fill);
        end

        // the partial write from above is finished by the first full burst
        hold_req = 1'b1;
        while (stim_items < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_write_bytes(PAK_BYTES - wr_sent);
            else if (pick < 72)
                send_random_read();
            else if (pick < 85)
                send_random_other();
            else
                send_write_bytes($urandom_range(1, 8));
        end
        req.valid <= 1'b0;

        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
